// ===== rtl/spa_pkg.sv =====
package spa_pkg;

  localparam int MAX_TERMS = 16;
  localparam int IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W     = $clog2(MAX_TERMS + 1);
  localparam int COEF_W    = 16;
  localparam int EXP_W     = 16;
  localparam int SUM_W     = COEF_W + 1;
  localparam int WORD_W    = COEF_W + EXP_W;

  typedef enum logic [1:0] {
    OP_APPEND_A = 2'd0,
    OP_APPEND_B = 2'd1,
    OP_ADD      = 2'd2
  } spa_op_t;

  typedef enum logic {
    S_IDLE,
    S_MERGE
  } spa_state_t;

  typedef struct packed {
    logic append_a;
    logic append_b;
    logic start;
    logic step;
    logic finish;
  } spa_cmd_t;

  typedef struct packed {
    logic done;
    logic out_free;
  } spa_stat_t;

endpackage

// ===== rtl/sparse_polynomial_add_unit.sv =====
// Sparse polynomial adder. Operation 0 and 1 append a term (coefficient,
// exponent) to operand A or B, up to MAX_TERMS each; an append to a full
// operand is dropped and sets capacity_overflow. Operation 2 merges both
// operands by descending exponent, summing equal exponents and dropping zero
// sums, and emits one beat per sum term with last_term on the final one (or a
// single beat with is_term low if nothing remains); then both operands and the
// flag are cleared. An add walks both stores with a single compare-and-add unit,
// one merge step per free output slot, so output stalls hold it back. Input is
// stalled while an add runs.
module sparse_polynomial_add_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         operation,
  input  logic signed [spa_pkg::COEF_W-1:0]  coefficient,
  input  logic [spa_pkg::EXP_W-1:0]          exponent,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [spa_pkg::SUM_W-1:0]   sum_coefficient,
  output logic [spa_pkg::EXP_W-1:0]          sum_exponent,
  output logic                               is_term,
  output logic                               last_term,
  output logic                               capacity_overflow
);
  import spa_pkg::*;

  spa_cmd_t  cmd;
  spa_stat_t stat;

  spa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .operation (operation),
    .in_stall  (in_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  spa_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .coefficient       (coefficient),
    .exponent          (exponent),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .sum_coefficient   (sum_coefficient),
    .sum_exponent      (sum_exponent),
    .is_term           (is_term),
    .last_term         (last_term),
    .capacity_overflow (capacity_overflow)
  );

endmodule

// ===== rtl/spa_ctrl.sv =====
module spa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        operation,
  output logic              in_stall,
  input  spa_pkg::spa_stat_t stat,
  output spa_pkg::spa_cmd_t  cmd
);
  import spa_pkg::*;

  spa_state_t state;
  spa_state_t state_next;
  logic       accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = (state != S_IDLE);
    accept     = in_valid && !in_stall;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (operation)
            OP_APPEND_A: cmd.append_a = 1'b1;
            OP_APPEND_B: cmd.append_b = 1'b1;
            OP_ADD: begin
              cmd.start  = 1'b1;
              state_next = S_MERGE;
            end
            default: ;
          endcase
        end
      end
      S_MERGE: begin
        // one merge step per free output slot
        if (stat.out_free) begin
          if (stat.done) begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/spa_datapath.sv =====
module spa_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  spa_pkg::spa_cmd_t                  cmd,
  output spa_pkg::spa_stat_t                 stat,
  input  logic signed [spa_pkg::COEF_W-1:0]  coefficient,
  input  logic [spa_pkg::EXP_W-1:0]          exponent,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [spa_pkg::SUM_W-1:0]   sum_coefficient,
  output logic [spa_pkg::EXP_W-1:0]          sum_exponent,
  output logic                               is_term,
  output logic                               last_term,
  output logic                               capacity_overflow
);
  import spa_pkg::*;

  logic [WORD_W-1:0] store_a [MAX_TERMS];
  logic [WORD_W-1:0] store_b [MAX_TERMS];
  logic [CNT_W-1:0]  cnt_a;
  logic [CNT_W-1:0]  cnt_b;
  logic [CNT_W-1:0]  ia;
  logic [CNT_W-1:0]  ib;
  logic              ovf;

  // pending term: held back until we know whether it is the last one
  logic              hold_valid;
  logic [SUM_W-1:0]  hold_coef;
  logic [EXP_W-1:0]  hold_exp;

  logic [WORD_W-1:0] wa;
  logic [WORD_W-1:0] wb;
  logic [EXP_W-1:0]  ea;
  logic [EXP_W-1:0]  eb;
  logic [SUM_W-1:0]  ca;
  logic [SUM_W-1:0]  cb;
  logic              a_left;
  logic              b_left;
  logic              adv_a;
  logic              adv_b;
  logic              emit;
  logic [SUM_W-1:0]  cand_coef;
  logic [EXP_W-1:0]  cand_exp;

  assign a_left = (ia < cnt_a);
  assign b_left = (ib < cnt_b);
  assign wa     = store_a[ia[IDX_W-1:0]];
  assign wb     = store_b[ib[IDX_W-1:0]];
  assign ea     = wa[WORD_W-1:COEF_W];
  assign eb     = wb[WORD_W-1:COEF_W];
  assign ca     = {wa[COEF_W-1], wa[COEF_W-1:0]};
  assign cb     = {wb[COEF_W-1], wb[COEF_W-1:0]};

  always_comb begin
    adv_a     = 1'b0;
    adv_b     = 1'b0;
    emit      = 1'b1;
    cand_coef = cb;
    cand_exp  = eb;
    if (a_left && b_left) begin
      if (ea == eb) begin
        cand_coef = ca + cb;
        cand_exp  = ea;
        emit      = (cand_coef != '0);
        adv_a     = 1'b1;
        adv_b     = 1'b1;
      end else if (ea > eb) begin
        cand_coef = ca;
        cand_exp  = ea;
        adv_a     = 1'b1;
      end else begin
        adv_b     = 1'b1;
      end
    end else if (a_left) begin
      cand_coef = ca;
      cand_exp  = ea;
      adv_a     = 1'b1;
    end else begin
      adv_b     = 1'b1;
    end
  end

  assign stat.done     = !a_left && !b_left;
  assign stat.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.append_a && (cnt_a != CNT_W'(MAX_TERMS))) begin
      store_a[cnt_a[IDX_W-1:0]] <= {exponent, coefficient};
    end
    if (cmd.append_b && (cnt_b != CNT_W'(MAX_TERMS))) begin
      store_b[cnt_b[IDX_W-1:0]] <= {exponent, coefficient};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_a      <= '0;
      cnt_b      <= '0;
      ovf        <= 1'b0;
      ia         <= '0;
      ib         <= '0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // a new beat loads over the one that leaves this cycle
      if (cmd.finish || (cmd.step && emit && hold_valid)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.append_a) begin
        if (cnt_a == CNT_W'(MAX_TERMS)) begin
          ovf <= 1'b1;
        end else begin
          cnt_a <= cnt_a + CNT_W'(1);
        end
      end
      if (cmd.append_b) begin
        if (cnt_b == CNT_W'(MAX_TERMS)) begin
          ovf <= 1'b1;
        end else begin
          cnt_b <= cnt_b + CNT_W'(1);
        end
      end
      if (cmd.start) begin
        ia         <= '0;
        ib         <= '0;
        hold_valid <= 1'b0;
      end
      if (cmd.step) begin
        if (adv_a) begin
          ia <= ia + CNT_W'(1);
        end
        if (adv_b) begin
          ib <= ib + CNT_W'(1);
        end
        if (emit) begin
          hold_valid <= 1'b1;
        end
      end
      if (cmd.finish) begin
        hold_valid <= 1'b0;
        cnt_a      <= '0;
        cnt_b      <= '0;
        ovf        <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && emit) begin
      hold_coef <= cand_coef;
      hold_exp  <= cand_exp;
      if (hold_valid) begin
        sum_coefficient   <= hold_coef;
        sum_exponent      <= hold_exp;
        is_term           <= 1'b1;
        last_term         <= 1'b0;
        capacity_overflow <= ovf;
      end
    end
    if (cmd.finish) begin
      // empty sum gives a single marker beat
      sum_coefficient   <= hold_valid ? hold_coef : '0;
      sum_exponent      <= hold_valid ? hold_exp : '0;
      is_term           <= hold_valid;
      last_term         <= 1'b1;
      capacity_overflow <= ovf;
    end
  end

endmodule

// ===== rtl/spa_checker.sv =====
module spa_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic [1:0]                         operation,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [spa_pkg::SUM_W-1:0]   sum_coefficient,
  input logic [spa_pkg::EXP_W-1:0]          sum_exponent,
  input logic                               is_term,
  input logic                               last_term
);
  import spa_pkg::*;

  // an accepted add holds off the input side until the run ends
  a_add_stalls: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && operation == OP_ADD) |=> in_stall)
    else $error("input not stalled after add");

  // only the last beat of a run can appear while the input is open
  a_mid_run: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last_term) |-> in_stall)
    else $error("non-last beat outside a run");

  a_marker: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !is_term) |->
      (last_term && sum_coefficient == '0 && sum_exponent == '0))
    else $error("bad empty marker beat");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(sum_coefficient)))
    else $error("stalled beat dropped or changed");

endmodule

bind sparse_polynomial_add_unit spa_checker u_spa_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .operation       (operation),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .sum_coefficient (sum_coefficient),
  .sum_exponent    (sum_exponent),
  .is_term         (is_term),
  .last_term       (last_term)
);

// ===== tb/sparse_polynomial_add_unit_tb.sv =====
module sparse_polynomial_add_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spa_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int GAP_MAX        = 12;
  localparam int HOLD_CYCLES    = 300;
  localparam int HOLD_AFTER     = 150;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TARGET_ITEMS   = 500;
  localparam int DRAIN_CYCLES   = 2 * MAX_TERMS + 20;
  localparam int PRINT_LIMIT    = 40;

  typedef struct {
    logic [1:0]               op;
    logic signed [COEF_W-1:0] coef;
    logic [EXP_W-1:0]         expo;
    int                       gap;
  } op_item_t;

  typedef struct {
    logic signed [SUM_W-1:0] coef;
    logic [EXP_W-1:0]        expo;
    logic                    is_term;
    logic                    last;
    logic                    ovf;
  } sum_term_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [1:0]               operation = '0;
  logic signed [COEF_W-1:0] coefficient = '0;
  logic [EXP_W-1:0]         exponent = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [SUM_W-1:0]  sum_coefficient;
  logic [EXP_W-1:0]         sum_exponent;
  logic                     is_term;
  logic                     last_term;
  logic                     capacity_overflow;

  sparse_polynomial_add_unit u_top (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .operation         (operation),
    .coefficient       (coefficient),
    .exponent          (exponent),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .sum_coefficient   (sum_coefficient),
    .sum_exponent      (sum_exponent),
    .is_term           (is_term),
    .last_term         (last_term),
    .capacity_overflow (capacity_overflow)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow of the two operand stores
  logic signed [COEF_W-1:0] a_coef [MAX_TERMS];
  logic [EXP_W-1:0]         a_exp  [MAX_TERMS];
  logic signed [COEF_W-1:0] b_coef [MAX_TERMS];
  logic [EXP_W-1:0]         b_exp  [MAX_TERMS];
  int                       a_count = 0;
  int                       b_count = 0;
  logic                     ovf_seen = 1'b0;

  op_item_t  op_queue[$];
  sum_term_t expected_terms[$];
  op_item_t  cur_item;

  int   real_items = 0;
  int   items_accepted = 0;
  int   adds_done = 0;
  int   overflow_adds = 0;
  int   empty_sums = 0;
  int   beats_checked = 0;
  int   mismatches = 0;
  int   tx_gap = -1;
  logic tx_next;
  int   rx_wait = 0;
  logic rx_calm = 1'b0;
  logic rx_hold = 1'b0;
  int   stuck_cycles = 0;

  task automatic report_mismatch(string field, longint got, longint want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("%0t: %s: got %0d, expected %0d", $time, field, got, want);
  endtask

  function automatic sum_term_t make_term(logic signed [SUM_W-1:0] c, logic [EXP_W-1:0] e,
                                          logic t);
    sum_term_t r;
    r.coef    = c;
    r.expo    = e;
    r.is_term = t;
    r.last    = 1'b0;
    r.ovf     = ovf_seen;
    return r;
  endfunction

  // updates the shadow stores and queues the sum beats that an add produces
  task automatic apply_op(op_item_t it);
    sum_term_t               run [2*MAX_TERMS];
    int                      n;
    int                      ia;
    int                      ib;
    logic signed [SUM_W-1:0] ca;
    logic signed [SUM_W-1:0] cb;
    n  = 0;
    ia = 0;
    ib = 0;
    if (it.op == OP_APPEND_A) begin
      if (a_count >= MAX_TERMS) ovf_seen = 1'b1;
      else begin
        a_coef[a_count] = it.coef;
        a_exp[a_count]  = it.expo;
        a_count++;
      end
    end else if (it.op == OP_APPEND_B) begin
      if (b_count >= MAX_TERMS) ovf_seen = 1'b1;
      else begin
        b_coef[b_count] = it.coef;
        b_exp[b_count]  = it.expo;
        b_count++;
      end
    end else if (it.op == OP_ADD) begin
      adds_done++;
      if (ovf_seen) overflow_adds++;
      while (ia < a_count && ib < b_count) begin
        ca = a_coef[ia];
        cb = b_coef[ib];
        if (a_exp[ia] == b_exp[ib]) begin
          if (ca + cb != 0) run[n++] = make_term(ca + cb, a_exp[ia], 1'b1);
          ia++;
          ib++;
        end else if (a_exp[ia] > b_exp[ib]) begin
          run[n++] = make_term(ca, a_exp[ia], 1'b1);
          ia++;
        end else begin
          run[n++] = make_term(cb, b_exp[ib], 1'b1);
          ib++;
        end
      end
      for (; ia < a_count; ia++) begin
        ca = a_coef[ia];
        run[n++] = make_term(ca, a_exp[ia], 1'b1);
      end
      for (; ib < b_count; ib++) begin
        cb = b_coef[ib];
        run[n++] = make_term(cb, b_exp[ib], 1'b1);
      end
      if (n == 0) begin
        run[n++] = make_term('0, '0, 1'b0);
        empty_sums++;
      end
      run[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) expected_terms.push_back(run[i]);
      a_count  = 0;
      b_count  = 0;
      ovf_seen = 1'b0;
    end
  endtask

  task automatic check_beat();
    sum_term_t want;
    beats_checked++;
    if (expected_terms.size() == 0) begin
      report_mismatch("beat with nothing expected, exponent", sum_exponent, 0);
      return;
    end
    want = expected_terms.pop_front();
    if (sum_coefficient !== want.coef)
      report_mismatch("sum_coefficient", sum_coefficient, want.coef);
    if (sum_exponent !== want.expo)
      report_mismatch("sum_exponent", sum_exponent, want.expo);
    if (is_term !== want.is_term) report_mismatch("is_term", is_term, want.is_term);
    if (last_term !== want.last) report_mismatch("last_term", last_term, want.last);
    if (capacity_overflow !== want.ovf)
      report_mismatch("capacity_overflow", capacity_overflow, want.ovf);
  endtask

  task automatic push_op(logic [1:0] op, logic signed [COEF_W-1:0] c, logic [EXP_W-1:0] e,
                         bit calm);
    op_item_t it;
    it.op   = op;
    it.coef = c;
    it.expo = e;
    it.gap  = calm ? 0 : $urandom_range(0, GAP_MAX);
    op_queue.push_back(it);
    if (op != OP_UNUSED) real_items++;
  endtask

  function automatic logic signed [COEF_W-1:0] draw_coef();
    if ($urandom_range(0, 15) == 0) return '0;
    return COEF_W'($urandom);
  endfunction

  // one run of appends to both operands followed by an add
  task automatic gen_add_run(bit force_full);
    logic [EXP_W-1:0]         ea[$];
    logic [EXP_W-1:0]         eb[$];
    logic signed [COEF_W-1:0] ca[$];
    logic signed [COEF_W-1:0] cb[$];
    int                       na;
    int                       nb;
    int                       ia;
    int                       ib;
    int                       hit;
    bit                       unsorted;
    bit                       narrow;
    bit                       calm;
    unsorted = ($urandom_range(0, 7) == 0);
    narrow   = ($urandom_range(0, 2) == 0);
    calm     = ($urandom_range(0, 3) == 0);
    na = $urandom_range(0, MAX_TERMS);
    nb = $urandom_range(0, MAX_TERMS);
    if (force_full || $urandom_range(0, 7) == 0) na = MAX_TERMS + $urandom_range(1, 3);
    if ($urandom_range(0, 7) == 0) nb = MAX_TERMS + $urandom_range(1, 3);
    for (int j = 0; j < na; j++)
      ea.push_back(narrow ? EXP_W'($urandom_range(0, 40)) : EXP_W'($urandom));
    for (int j = 0; j < nb; j++) begin
      if (na > 0 && $urandom_range(0, 1) == 1) eb.push_back(ea[$urandom_range(0, na - 1)]);
      else eb.push_back(narrow ? EXP_W'($urandom_range(0, 40)) : EXP_W'($urandom));
    end
    if (!unsorted) begin
      ea.rsort();
      eb.rsort();
    end
    for (int j = 0; j < na; j++) ca.push_back(draw_coef());
    // some shared exponents get opposite coefficients so the sum cancels
    for (int j = 0; j < nb; j++) begin
      hit = -1;
      for (int k = 0; k < na; k++) if (ea[k] == eb[j]) hit = k;
      if (hit >= 0 && $urandom_range(0, 2) == 0) cb.push_back(-ca[hit]);
      else cb.push_back(draw_coef());
    end
    ia = 0;
    ib = 0;
    while (ia < na || ib < nb) begin
      if (ib >= nb || (ia < na && $urandom_range(0, 1) == 1)) begin
        push_op(OP_APPEND_A, ca[ia], ea[ia], calm);
        ia++;
      end else begin
        push_op(OP_APPEND_B, cb[ib], eb[ib], calm);
        ib++;
      end
      if ($urandom_range(0, 24) == 0) push_op(OP_UNUSED, COEF_W'($urandom), EXP_W'($urandom), calm);
    end
    push_op(OP_ADD, COEF_W'($urandom), EXP_W'($urandom), calm);
  endtask

  // driver: one beat at a time from op_queue, with a drawn gap before each
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap = -1;
    end else begin
      tx_next = in_valid;
      if (in_valid && !in_stall) begin
        apply_op(cur_item);
        items_accepted++;
        tx_next = 1'b0;
      end
      if (!tx_next && op_queue.size() > 0) begin
        if (tx_gap < 0) tx_gap = op_queue[0].gap;
        if (tx_gap == 0) begin
          cur_item = op_queue.pop_front();
          operation   <= cur_item.op;
          coefficient <= cur_item.coef;
          exponent    <= cur_item.expo;
          tx_next = 1'b1;
          tx_gap  = -1;
        end else begin
          tx_gap--;
        end
      end
      in_valid <= tx_next;
    end
  end

  // monitor: checks each output beat, then stalls for a drawn number of cycles
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        check_beat();
        rx_wait = rx_calm ? 0 : $urandom_range(0, GAP_MAX);
        if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_stall <= rx_hold || (rx_wait > 0);
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (items_accepted >= HOLD_AFTER);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    // empty sum
    push_op(OP_ADD, '0, '0, 1'b0);
    // coefficient and exponent extremes
    push_op(OP_APPEND_A, 16'sh7fff, 16'hffff, 1'b0);
    push_op(OP_APPEND_A, 16'sh8000, 16'h0000, 1'b0);
    push_op(OP_APPEND_B, 16'sh7fff, 16'hffff, 1'b0);
    push_op(OP_APPEND_B, 16'sh8000, 16'h0000, 1'b0);
    push_op(OP_ADD, 16'sh7fff, 16'hffff, 1'b0);
    // cancelling terms leave an empty sum
    push_op(OP_APPEND_A, 16'sd100, 16'd5, 1'b0);
    push_op(OP_APPEND_B, -16'sd100, 16'd5, 1'b0);
    push_op(OP_ADD, '0, '0, 1'b0);
    // zero coefficient passes through
    push_op(OP_APPEND_A, 16'sd0, 16'd7, 1'b1);
    push_op(OP_APPEND_B, 16'sd3, 16'd2, 1'b1);
    push_op(OP_ADD, '0, '0, 1'b1);
    // unused code, then an unsorted operand
    push_op(OP_UNUSED, 16'shffff, 16'hffff, 1'b0);
    push_op(OP_APPEND_A, 16'sd1, 16'd1, 1'b0);
    push_op(OP_APPEND_A, 16'sd2, 16'd9, 1'b0);
    push_op(OP_APPEND_B, 16'sd5, 16'd5, 1'b0);
    push_op(OP_ADD, '0, '0, 1'b0);
    gen_add_run(1'b1);
    while (real_items < TARGET_ITEMS) gen_add_run(1'b0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (op_queue.size() != 0 || in_valid || expected_terms.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d input beats: %0d adds, %0d with dropped appends, %0d empty sums",
             items_accepted, adds_done, overflow_adds, empty_sums);
    $display("checked %0d sum beats, %0d field errors", beats_checked, mismatches);
    if (mismatches == 0 && expected_terms.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/spa_pkg.sv
rtl/spa_ctrl.sv
rtl/spa_datapath.sv
rtl/sparse_polynomial_add_unit.sv
rtl/spa_checker.sv
tb/sparse_polynomial_add_unit_tb.sv
